[hw/rtl/stcs_pkg.sv]
// ---------------------------------------------------------------------------
// stcs_pkg
// Shared types and constants for the wall column setup pipeline.
// ---------------------------------------------------------------------------
package stcs_pkg;

    localparam int SCREEN_WIDTH    = 320;
    localparam int MAX_VIEW_HEIGHT = 160;
    localparam int TEX_SIZE        = 128;

    localparam int X_W     = 9;
    localparam int SCALE_W = 11;
    localparam int COL_W   = 8;
    localparam int CLR_W   = 8;
    localparam int ROW_W   = 8;
    localparam int OFS_W   = 16;
    localparam int TBASE_W = 14;
    localparam int FRAC_W  = 16;
    localparam int STEP_W  = 23;
    localparam int DET_W   = 2;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // 2^30 / scale, worked as a 32-bit dividend, MSB first
    localparam int QUO_W       = 32;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = QUO_W / DIV_STEPS;
    localparam int RECIP_W     = 31;
    localparam int LY_W        = 24;
    localparam int XS_W        = X_W + 2;

    // front, divider stages, multiply, output
    localparam int NUM_STAGES  = DIV_STAGES + 3;
    localparam int MUL_STAGE   = DIV_STAGES + 1;
    localparam int OUT_STAGE   = DIV_STAGES + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETAIL_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_BASE    = 2'd2;

    localparam logic [DET_W-1:0] DET_MAX = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0]   start_row;
        logic [ROW_W-1:0]   row_count;
        logic [XS_W-1:0]    xs;
        logic [OFS_W-1:0]   screen_offset;
        logic               fill_flat;
        logic [CLR_W-1:0]   colour;
        logic [TBASE_W-1:0] texel_base;
        logic [SCALE_W-1:0] skip;
        logic [SCALE_W-1:0] scale;
        logic [SCALE_W-1:0] rem;
        logic [QUO_W-1:0]   quo;
        logic [LY_W-1:0]    ly;
        logic [STEP_W-1:0]  frac_step;
        logic [FRAC_W-1:0]  frac_start;
    } t_item;

endpackage

[hw/rtl/stcs_div_stage.sv]
// ---------------------------------------------------------------------------
// stcs_div_stage
// Restoring division slice: DIV_STEPS quotient bits of dividend / scale.
// ---------------------------------------------------------------------------
module stcs_div_stage (
    input  logic [stcs_pkg::DIV_STEPS-1:0] i_num_bits,
    input  logic [stcs_pkg::SCALE_W-1:0]   i_scale,
    input  logic [stcs_pkg::SCALE_W-1:0]   i_rem,
    input  logic [stcs_pkg::QUO_W-1:0]     i_quo,
    output logic [stcs_pkg::SCALE_W-1:0]   o_rem,
    output logic [stcs_pkg::QUO_W-1:0]     o_quo
);
    import stcs_pkg::*;

    always_comb begin
        logic [SCALE_W-1:0] rem;
        logic [QUO_W-1:0]   quo;
        logic [SCALE_W:0]   sh;
        rem = i_rem;
        quo = i_quo;
        for (int j = DIV_STEPS - 1; j >= 0; j--) begin
            sh = {rem, i_num_bits[j]};
            if (sh >= {1'b0, i_scale}) begin
                sh  = sh - {1'b0, i_scale};
                quo = {quo[QUO_W-2:0], 1'b1};
            end else begin
                quo = {quo[QUO_W-2:0], 1'b0};
            end
            rem = sh[SCALE_W-1:0];
        end
        o_rem = rem;
        o_quo = quo;
    end

endmodule

[hw/rtl/scaled_texture_column_setup.sv]
// ---------------------------------------------------------------------------
// scaled_texture_column_setup
// Wall column setup: start row, row count, screen offset and texel stepping.
// ---------------------------------------------------------------------------
// One column request per cycle while the output is not stalled. The
// latency comes from the reciprocal 2^30/scale, a restoring divider
// spread over 8 stages of 4 quotient bits, followed by one stage for the
// skip*recip multiply and the output register.
// Stalls back up stage by stage; empty stages fill, so bubbles are absorbed.
// Zero-scale beats are accepted and produce no result.
module scaled_texture_column_setup (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [stcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stcs_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [stcs_pkg::X_W-1:0]        i_screen_x,
    input  logic [stcs_pkg::SCALE_W-1:0]    i_wall_scale,
    input  logic [stcs_pkg::COL_W-1:0]      i_tex_column,
    input  logic [stcs_pkg::CLR_W-1:0]      i_flat_colour,
    input  logic                            i_has_texture,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [stcs_pkg::ROW_W-1:0]      o_start_row,
    output logic [stcs_pkg::ROW_W-1:0]      o_row_count,
    output logic [stcs_pkg::OFS_W-1:0]      o_screen_offset,
    output logic                            o_fill_flat,
    output logic [stcs_pkg::CLR_W-1:0]      o_colour_out,
    output logic [stcs_pkg::TBASE_W-1:0]    o_texel_base,
    output logic [stcs_pkg::FRAC_W-1:0]     o_frac_start,
    output logic [stcs_pkg::STEP_W-1:0]     o_frac_step
);
    import stcs_pkg::*;

    logic [ROW_W-1:0] r_vh;
    logic [DET_W-1:0] r_det;
    logic [OFS_W-1:0] r_base;

    logic  r_v  [NUM_STAGES];
    t_item r_it [NUM_STAGES];
    t_item n_it [NUM_STAGES];
    logic  rdy  [NUM_STAGES+1];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh   <= ROW_W'(MAX_VIEW_HEIGHT);
            r_det  <= '0;
            r_base <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_VIEW_HEIGHT: begin
                    if (int'(i_cfg_data[ROW_W-1:0]) > MAX_VIEW_HEIGHT) begin
                        r_vh <= ROW_W'(MAX_VIEW_HEIGHT);
                    end else begin
                        r_vh <= i_cfg_data[ROW_W-1:0];
                    end
                end
                CFG_DETAIL_SHIFT: begin
                    r_det <= (i_cfg_data[DET_W-1:0] > DET_MAX) ? DET_MAX
                                                              : i_cfg_data[DET_W-1:0];
                end
                CFG_VIEW_BASE: r_base <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage readiness: a stage loads when empty or when it moves on
    assign rdy[NUM_STAGES] = !i_stall;
    generate
        for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
            assign rdy[k] = !r_v[k] || rdy[k+1];
        end
    endgenerate
    assign o_stall = !rdy[0];

    // front stage: geometry and divider seed
    always_comb begin
        logic [SCALE_W:0] h;
        logic [SCALE_W:0] vh;
        logic [SCALE_W:0] d;
        h  = {i_wall_scale, 1'b0};
        vh = (SCALE_W+1)'(r_vh);
        n_it[0] = '0;
        if (h < vh) begin
            d = vh - h;
            n_it[0].start_row = d[ROW_W:1];
            n_it[0].row_count = h[ROW_W-1:0];
        end else begin
            d = h - vh;
            n_it[0].start_row = '0;
            n_it[0].row_count = r_vh;
        end
        n_it[0].xs         = XS_W'({2'b00, i_screen_x} << r_det);
        n_it[0].fill_flat  = !i_has_texture;
        n_it[0].colour     = i_has_texture ? '0 : i_flat_colour;
        n_it[0].texel_base = i_has_texture
                           ? TBASE_W'((int'(i_tex_column) % TEX_SIZE) * TEX_SIZE) : '0;
        n_it[0].skip       = (i_has_texture && (h > vh)) ? d[SCALE_W:1] : '0;
        n_it[0].scale      = i_wall_scale;
    end

    // divider stages; the first also forms the screen offset
    generate
        for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
            logic [SCALE_W-1:0] rem;
            logic [QUO_W-1:0]   quo;
            localparam logic [DIV_STEPS-1:0] NUM =
                (k == 1) ? DIV_STEPS'(1 << (DIV_STEPS - 2)) : '0;

            stcs_div_stage u_div (
                .i_num_bits (NUM),
                .i_scale    (r_it[k-1].scale),
                .i_rem      (r_it[k-1].rem),
                .i_quo      (r_it[k-1].quo),
                .o_rem      (rem),
                .o_quo      (quo)
            );

            always_comb begin
                n_it[k]     = r_it[k-1];
                n_it[k].rem = rem;
                n_it[k].quo = quo;
                if (k == 1) begin
                    n_it[k].screen_offset = r_base
                        + OFS_W'(int'(r_it[k-1].start_row) * SCREEN_WIDTH)
                        + OFS_W'(r_it[k-1].xs);
                end
            end
        end
    endgenerate

    // skip * recip, and the frac step
    always_comb begin
        logic [SCALE_W+RECIP_W-1:0] prod;
        prod = r_it[MUL_STAGE-1].skip * r_it[MUL_STAGE-1].quo[RECIP_W-1:0];
        n_it[MUL_STAGE]    = r_it[MUL_STAGE-1];
        n_it[MUL_STAGE].ly = prod[LY_W+7:8];
        n_it[MUL_STAGE].frac_step = r_it[MUL_STAGE-1].fill_flat
                                  ? '0 : r_it[MUL_STAGE-1].quo[RECIP_W-1:8];
    end

    // texel base and start fraction
    always_comb begin
        n_it[OUT_STAGE] = r_it[OUT_STAGE-1];
        n_it[OUT_STAGE].texel_base = r_it[OUT_STAGE-1].texel_base
                                   + TBASE_W'(r_it[OUT_STAGE-1].ly[LY_W-1:FRAC_W]);
        n_it[OUT_STAGE].frac_start = r_it[OUT_STAGE-1].ly[FRAC_W-1:0];
    end

    // stage registers
    generate
        for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
            if (k == 0) begin : g_head
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (rdy[k]) begin
                        r_v[k] <= i_valid && (i_wall_scale != '0);
                    end
                end
            end else begin : g_body
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (rdy[k]) begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[k]) begin
                    r_it[k] <= n_it[k];
                end
            end
        end
    endgenerate

    assign o_valid         = r_v[OUT_STAGE];
    assign o_start_row     = r_it[OUT_STAGE].start_row;
    assign o_row_count     = r_it[OUT_STAGE].row_count;
    assign o_screen_offset = r_it[OUT_STAGE].screen_offset;
    assign o_fill_flat     = r_it[OUT_STAGE].fill_flat;
    assign o_colour_out    = r_it[OUT_STAGE].colour;
    assign o_texel_base    = r_it[OUT_STAGE].texel_base;
    assign o_frac_start    = r_it[OUT_STAGE].frac_start;
    assign o_frac_step     = r_it[OUT_STAGE].frac_step;

endmodule
